// ----- src/tsdc_pkg.sv -----
// Shared types and constants of the two-sensor direction counter.
`timescale 1ns / 1ps
`default_nettype none

package tsdc_pkg;

    localparam int unsigned DIST_W     = 16;
    localparam int unsigned RANGE_W    = 13;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned WINDOW_W   = 16;
    localparam int unsigned REPORT_W   = 8;
    localparam int unsigned COUNT_BITS = 8;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [RANGE_W-1:0]  THRESHOLD_RST = RANGE_W'(350);
    localparam logic [RANGE_W-1:0]  RANGE_RST     = RANGE_W'(2001);
    localparam logic [WINDOW_W-1:0] WINDOW_RST    = WINDOW_W'(1000);
    localparam logic [WINDOW_W-1:0] HOLDOFF_RST   = WINDOW_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_RANGE     = 2'd1,
        REG_WINDOW    = 2'd2,
        REG_HOLDOFF   = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTRY = 2'd1,
        EV_EXIT  = 2'd2
    } t_event;

endpackage

`default_nettype wire

// ----- src/tsdc_in_if.sv -----
// Input channel: a pair of readings, a timestamp and a clear request.
`timescale 1ns / 1ps
`default_nettype none

interface tsdc_in_if
    import tsdc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DIST_W-1:0]   dist_a;
    logic [DIST_W-1:0]   dist_b;
    logic [TIME_W-1:0]   now_ms;
    logic                clear_count;

    modport source (output valid, output dist_a, output dist_b, output now_ms,
                    output clear_count, input ready);
    modport sink   (input valid, input dist_a, input dist_b, input now_ms,
                    input clear_count, output ready);
endinterface

`default_nettype wire

// ----- src/tsdc_out_if.sv -----
// Output channel: count report for each transaction.
`timescale 1ns / 1ps
`default_nettype none

interface tsdc_out_if
    import tsdc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [REPORT_W-1:0] people_count;
    logic [1:0]          count_event;
    logic                count_changed;
    logic                occupied;

    modport source (output valid, output people_count, output count_event,
                    output count_changed, output occupied, input ready);
    modport sink   (input valid, input people_count, input count_event,
                    input count_changed, input occupied, output ready);
endinterface

`default_nettype wire

// ----- src/two_sensor_direction_counter_core.sv -----
// Two-sensor direction counter: input register, combinational update, result register.
// An accepted transaction moves from the input register into the result register once that is free.
// Throughput: one transaction per cycle; the single compare/add pass on the held
// sensor state sets this. A result held by the sink stalls the input once the input
// register is full. Reset (synchronous, active low): configuration returns to its
// defaults, all sensor state, the count and the hold-off time clear, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module two_sensor_direction_counter_core
    import tsdc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    tsdc_in_if.sink                   i_in,
    tsdc_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // configuration
    logic [RANGE_W-1:0]  r_threshold;
    logic [RANGE_W-1:0]  r_range;
    logic [WINDOW_W-1:0] r_window;
    logic [WINDOW_W-1:0] r_holdoff;

    // sensor state
    logic [RANGE_W-1:0]    r_last_a, r_last_b;
    logic [TIME_W-1:0]     r_time_a, r_time_b;
    logic [TIME_W-1:0]     r_ignore_until;
    logic [COUNT_BITS-1:0] r_occ;

    // input register
    logic                r_in_valid;
    logic [DIST_W-1:0]   r_in_da, r_in_db;
    logic [TIME_W-1:0]   r_in_now;
    logic                r_in_clear;

    // result register
    logic                r_out_valid;
    logic [REPORT_W-1:0] r_out_count;
    t_event              r_out_event;
    logic                r_out_changed;
    logic                r_out_occupied;

    logic s1_adv;
    logic in_ready;

    // next-state values
    logic [RANGE_W-1:0]    n_last_a, n_last_b;
    logic [TIME_W-1:0]     n_time_a, n_time_b;
    logic [TIME_W-1:0]     n_ignore_until;
    logic [COUNT_BITS-1:0] n_occ;
    t_event                n_event;
    logic                  n_changed;

    logic [RANGE_W-1:0] da_c, db_c, db_eff;
    logic               active, a_moved, b_moved, exit_hit, entry_hit;
    logic [TIME_W-1:0]  diff_b, diff_a;
    logic [TIME_W:0]    until_sum;
    logic [TIME_W-1:0]  until_sat;

    function automatic logic f_moved(input logic [RANGE_W-1:0] rd,
                                     input logic [RANGE_W-1:0] prev,
                                     input logic [RANGE_W-1:0] thr);
        logic [RANGE_W:0] hi;
        logic [RANGE_W:0] lo;
        hi = {1'b0, prev} + {1'b0, thr};
        lo = {1'b0, rd} + {1'b0, thr};
        return (rd != '0) && (({1'b0, rd} > hi) || (lo < {1'b0, prev}));
    endfunction

    assign s1_adv   = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || s1_adv;
    assign i_in.ready = in_ready;

    always_comb begin
        da_c = (r_in_da > DIST_W'(r_range)) ? r_range : r_in_da[RANGE_W-1:0];
        db_c = (r_in_db > DIST_W'(r_range)) ? r_range : r_in_db[RANGE_W-1:0];

        active  = !r_in_clear && (r_in_now >= r_ignore_until);
        a_moved = f_moved(da_c, r_last_a, r_threshold);

        // exit: A moves after B within the window, both readings below the limit
        diff_b   = r_in_now - r_time_b;
        exit_hit = active && a_moved && (r_in_now > r_time_b)
                   && (diff_b < TIME_W'(r_window))
                   && (da_c < r_range) && (db_c < r_range);

        // after an exit count the B reading reads as the range limit
        db_eff  = exit_hit ? r_range : db_c;
        b_moved = f_moved(db_eff, r_last_b, r_threshold);

        // entry: B moves after an earlier A event; an A event in this item rules it out
        diff_a    = r_in_now - r_time_a;
        entry_hit = active && b_moved && !a_moved && (r_in_now > r_time_a)
                    && (diff_a < TIME_W'(r_window))
                    && (da_c < r_range) && (db_c < r_range);

        until_sum = {1'b0, r_in_now} + (TIME_W + 1)'(r_holdoff);
        until_sat = until_sum[TIME_W] ? {TIME_W{1'b1}} : until_sum[TIME_W-1:0];

        n_last_a       = r_last_a;
        n_last_b       = r_last_b;
        n_time_a       = r_time_a;
        n_time_b       = r_time_b;
        n_ignore_until = r_ignore_until;
        n_occ          = r_occ;
        n_event        = EV_NONE;
        n_changed      = 1'b0;

        if (r_in_clear) begin
            n_occ     = '0;
            n_changed = (r_occ != '0);
        end else if (active) begin
            if (a_moved) begin
                n_time_a = r_in_now;
                n_last_a = da_c;
            end
            if (b_moved) begin
                n_time_b = r_in_now;
                n_last_b = db_eff;
            end
            if (entry_hit) begin
                n_event = EV_ENTRY;
                if (r_occ != COUNT_MAX) begin
                    n_occ = r_occ + COUNT_BITS'(1);
                end
            end else if (exit_hit) begin
                n_event = EV_EXIT;
                if (r_occ != '0) begin
                    n_occ = r_occ - COUNT_BITS'(1);
                end
            end
            if (b_moved) begin
                n_changed = (n_occ != r_occ);
            end
            if (entry_hit || exit_hit) begin
                n_time_b       = until_sat;
                n_ignore_until = until_sat;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_range     <= RANGE_RST;
            r_window    <= WINDOW_RST;
            r_holdoff   <= HOLDOFF_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_THRESHOLD: r_threshold <= i_cfg_data[RANGE_W-1:0];
                REG_RANGE:     r_range     <= i_cfg_data[RANGE_W-1:0];
                REG_WINDOW:    r_window    <= i_cfg_data[WINDOW_W-1:0];
                REG_HOLDOFF:   r_holdoff   <= i_cfg_data[WINDOW_W-1:0];
                default:       r_threshold <= r_threshold;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_da    <= i_in.dist_a;
            r_in_db    <= i_in.dist_b;
            r_in_now   <= i_in.now_ms;
            r_in_clear <= i_in.clear_count;
        end
    end

    // sensor state advances once per processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a       <= '0;
            r_last_b       <= '0;
            r_time_a       <= '0;
            r_time_b       <= '0;
            r_ignore_until <= '0;
            r_occ          <= '0;
        end else if (s1_adv) begin
            r_last_a       <= n_last_a;
            r_last_b       <= n_last_b;
            r_time_a       <= n_time_a;
            r_time_b       <= n_time_b;
            r_ignore_until <= n_ignore_until;
            r_occ          <= n_occ;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_count    <= REPORT_W'(n_occ);
            r_out_event    <= n_event;
            r_out_changed  <= n_changed;
            r_out_occupied <= (n_occ != '0);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.people_count  = r_out_count;
    assign o_out.count_event   = r_out_event;
    assign o_out.count_changed = r_out_changed;
    assign o_out.occupied      = r_out_occupied;

    // an entry always leaves at least one person inside
    a_entry_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_event == EV_ENTRY)) |-> r_out_occupied)
        else $error("entry reported with empty count");

    // the count moves only when a transaction is processed
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> $stable(r_occ))
        else $error("count changed without a transaction");

    // a count event pushes the hold-off time to at least the item timestamp
    a_holdoff_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && (n_event != EV_NONE)) |=> (r_ignore_until >= $past(r_in_now)))
        else $error("hold-off not armed after count event");

    // a clear request always reports an empty count
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_in_clear) |=> (r_occ == '0))
        else $error("clear request left a nonzero count");

endmodule

`default_nettype wire
